>>> rtl/cdps_pkg.sv
// Shared widths, constants and types for the divider pair search block.
`default_nettype none
package cdps_pkg;
   localparam int RATE_W = 32;
   localparam int PRE_W = 4;
   localparam int POST_W = 7;
   localparam int ERR_W = 32;
   localparam int PREDIV_MAX_DEF = 8;
   localparam int POSTDIV_MAX_DEF = 64;
   localparam logic [ERR_W-1:0] ALL_ONES = '1;

   typedef struct packed {
      logic start;
      logic [RATE_W-1:0] dividend;
   } div_cmd_type;
endpackage
`default_nettype wire

>>> rtl/clock_divider_pair_search.sv
// Top level of the divider pair search: search sequencer and result register.
// The search time is set by the single bit-serial divider, and each division
// ends with a step in which its quotient is taken. Each pre-divider first costs
// one division of the source rate. Each post-divider then costs one more
// division plus a compare of the error. Requests are handled one at a time. A
// new request is taken once the previous result has been transferred.
`default_nettype none
module clock_divider_pair_search #(
   parameter int PREDIV_MAX = cdps_pkg::PREDIV_MAX_DEF,
   parameter int POSTDIV_MAX = cdps_pkg::POSTDIV_MAX_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [cdps_pkg::RATE_W-1:0] req_target_rate,
   input  wire logic [cdps_pkg::RATE_W-1:0] req_source_rate,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [cdps_pkg::PRE_W-1:0] rsp_pre_divider,
   output logic [cdps_pkg::POST_W-1:0] rsp_post_divider,
   output logic [cdps_pkg::ERR_W-1:0] rsp_best_error,
   output logic rsp_found
);
   import cdps_pkg::*;

   localparam int I_W = $clog2(PREDIV_MAX + 1);
   localparam int J_W = $clog2(POSTDIV_MAX + 1);
   localparam int DIV_W = (I_W > J_W) ? I_W : J_W;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PRE  = 5'b00010,
      ST_POST = 5'b00100,
      ST_CMP  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [RATE_W-1:0] target_ff, target_in;
   logic [RATE_W-1:0] source_ff, source_in;
   logic [RATE_W-1:0] stage_ff, stage_in;
   logic [ERR_W-1:0] err_ff, err_in;
   logic [ERR_W-1:0] best_err_ff, best_err_in;
   logic [PRE_W-1:0] best_pre_ff, best_pre_in;
   logic [POST_W-1:0] best_post_ff, best_post_in;
   logic found_ff, found_in;
   logic [I_W-1:0] pre_cnt_ff, pre_cnt_in;
   logic [J_W-1:0] post_cnt_ff, post_cnt_in;
   logic [I_W-1:0] pre_next;
   logic [J_W-1:0] post_next;
   div_cmd_type div_cmd;
   logic [DIV_W-1:0] div_divisor;
   logic div_done;
   logic [RATE_W-1:0] div_quo;

   cdps_div_serial #(
      .DIV_W(DIV_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .cmd(div_cmd),
      .divisor(div_divisor),
      .done(div_done),
      .quotient(div_quo)
   );

   assign pre_next = I_W'(pre_cnt_ff + 1'b1);
   assign post_next = J_W'(post_cnt_ff + 1'b1);

   always_comb begin
      state_in = state_ff;
      target_in = target_ff;
      source_in = source_ff;
      stage_in = stage_ff;
      err_in = err_ff;
      best_err_in = best_err_ff;
      best_pre_in = best_pre_ff;
      best_post_in = best_post_ff;
      found_in = found_ff;
      pre_cnt_in = pre_cnt_ff;
      post_cnt_in = post_cnt_ff;
      div_cmd.start = 1'b0;
      div_cmd.dividend = source_ff;
      div_divisor = DIV_W'(pre_cnt_ff);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               target_in = req_target_rate;
               source_in = req_source_rate;
               best_err_in = ALL_ONES;
               best_pre_in = PRE_W'(1);
               best_post_in = POST_W'(1);
               found_in = 1'b0;
               pre_cnt_in = I_W'(1);
               post_cnt_in = J_W'(1);
               div_cmd.start = 1'b1;
               div_cmd.dividend = req_source_rate;
               div_divisor = DIV_W'(1);
               state_in = ST_PRE;
            end
         end
         ST_PRE: begin
            if (div_done) begin
               stage_in = div_quo;
               div_cmd.start = 1'b1;
               div_cmd.dividend = div_quo;
               div_divisor = DIV_W'(post_cnt_ff);
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (div_done) begin
               err_in = (div_quo >= target_ff) ? (div_quo - target_ff)
                                               : (target_ff - div_quo);
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (err_ff < best_err_ff) begin
               best_err_in = err_ff;
               best_pre_in = PRE_W'(pre_cnt_ff);
               best_post_in = POST_W'(post_cnt_ff);
               found_in = 1'b1;
            end
            if (post_cnt_ff != J_W'(POSTDIV_MAX)) begin
               post_cnt_in = post_next;
               div_cmd.start = 1'b1;
               div_cmd.dividend = stage_ff;
               div_divisor = DIV_W'(post_next);
               state_in = ST_POST;
            end else if (pre_cnt_ff != I_W'(PREDIV_MAX)) begin
               pre_cnt_in = pre_next;
               post_cnt_in = J_W'(1);
               div_cmd.start = 1'b1;
               div_cmd.dividend = source_ff;
               div_divisor = DIV_W'(pre_next);
               state_in = ST_PRE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      source_ff <= source_in;
      stage_ff <= stage_in;
      err_ff <= err_in;
      best_err_ff <= best_err_in;
      best_pre_ff <= best_pre_in;
      best_post_ff <= best_post_in;
      found_ff <= found_in;
      pre_cnt_ff <= pre_cnt_in;
      post_cnt_ff <= post_cnt_in;
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_pre_divider = best_pre_ff;
   assign rsp_post_divider = best_post_ff;
   assign rsp_best_error = best_err_ff;
   assign rsp_found = found_ff;

   a_best_never_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && $past(state_ff) != ST_IDLE)
      |-> best_err_ff <= $past(best_err_ff))
      else $error("best error grew during the search");

   a_not_found_defaults: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found)
      |-> (rsp_best_error == ALL_ONES && rsp_pre_divider == PRE_W'(1)
           && rsp_post_divider == POST_W'(1)))
      else $error("failed search does not report default values");

   a_found_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> rsp_best_error != ALL_ONES)
      else $error("found pair reports an all ones error");

   a_div_idle_on_cmp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> $past(div_done))
      else $error("compare reached without a finished division");
endmodule
`default_nettype wire

>>> rtl/cdps_div_serial.sv
// Restoring divider that produces one quotient bit per clock cycle.
`default_nettype none
module cdps_div_serial #(
   parameter int DIV_W = 9
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire cdps_pkg::div_cmd_type cmd,
   input  wire logic [DIV_W-1:0] divisor,
   output logic done,
   output logic [cdps_pkg::RATE_W-1:0] quotient
);
   import cdps_pkg::*;

   localparam int CNT_W = $clog2(RATE_W);

   logic [RATE_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [DIV_W:0] part;
   logic [DIV_W:0] diff;

   always_comb begin
      part = {rem_ff, quo_ff[RATE_W-1]};
      diff = part - {1'b0, dvs_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (cmd.start) begin
         quo_in = cmd.dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (!diff[DIV_W]) begin
            rem_in = diff[DIV_W-1:0];
            quo_in = {quo_ff[RATE_W-2:0], 1'b1};
         end else begin
            rem_in = part[DIV_W-1:0];
            quo_in = {quo_ff[RATE_W-2:0], 1'b0};
         end
         cnt_in = CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == CNT_W'(RATE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the divider pair search block.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import cdps_pkg::*;

   localparam int HOLD_CYCLES = 60000;
   localparam int STALL_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 20000;
   localparam int RANDOM_ITEMS = 100;

   typedef struct packed {
      logic [RATE_W-1:0] target;
      logic [RATE_W-1:0] source;
   } rate_request_type;

   typedef struct packed {
      logic [PRE_W-1:0] pre;
      logic [POST_W-1:0] post;
      logic [ERR_W-1:0] err;
      logic found;
   } divider_choice_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [RATE_W-1:0] req_target_rate = '0;
   logic [RATE_W-1:0] req_source_rate = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [PRE_W-1:0] rsp_pre_divider;
   logic [POST_W-1:0] rsp_post_divider;
   logic [ERR_W-1:0] rsp_best_error;
   logic rsp_found;

   rate_request_type pending_q[$];
   divider_choice_type expected_q[$];
   int total_items = 0;
   int issued_count = 0;
   int accepted_count = 0;
   int rsp_seen = 0;
   int error_count = 0;
   int hold_left = 0;
   bit hold_started = 1'b0;
   int stall_cycles = 0;
   logic offering;
   rate_request_type next_req;
   divider_choice_type want;

   clock_divider_pair_search u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_target_rate(req_target_rate),
      .req_source_rate(req_source_rate),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pre_divider(rsp_pre_divider),
      .rsp_post_divider(rsp_post_divider),
      .rsp_best_error(rsp_best_error),
      .rsp_found(rsp_found)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic divider_choice_type search_divider_pair(
      input logic [RATE_W-1:0] target,
      input logic [RATE_W-1:0] source
   );
      divider_choice_type pick;
      logic [RATE_W-1:0] stage;
      logic [RATE_W-1:0] rate;
      logic [ERR_W-1:0] diff;
      pick.pre = PRE_W'(1);
      pick.post = POST_W'(1);
      pick.err = ALL_ONES;
      pick.found = 1'b0;
      for (int unsigned i = 1; i <= PREDIV_MAX_DEF; i++) begin
         stage = source / RATE_W'(i);
         for (int unsigned j = 1; j <= POSTDIV_MAX_DEF; j++) begin
            rate = stage / RATE_W'(j);
            diff = (rate >= target) ? rate - target : target - rate;
            if (diff < pick.err) begin
               pick.err = diff;
               pick.pre = PRE_W'(i);
               pick.post = POST_W'(j);
               pick.found = 1'b1;
            end
         end
      end
      return pick;
   endfunction

   task automatic add_request(input logic [RATE_W-1:0] target, input logic [RATE_W-1:0] source);
      rate_request_type r;
      r.target = target;
      r.source = source;
      pending_q.push_back(r);
      total_items++;
   endtask

   task automatic flag_error(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Sender: offers queued requests and records the expected choice of each transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offering = req_valid;
         if (req_valid && req_ready) begin
            expected_q.push_back(search_divider_pair(req_target_rate, req_source_rate));
            accepted_count++;
            offering = 1'b0;
         end
         if (!offering && pending_q.size() != 0 &&
             ((issued_count >= 40 && issued_count < 70) || $urandom_range(99) >= 7)) begin
            next_req = pending_q.pop_front();
            issued_count++;
            req_target_rate <= next_req.target;
            req_source_rate <= next_req.source;
            offering = 1'b1;
         end
         req_valid <= offering;
      end
   end

   // Receiver: checks each transfer and throttles rsp_ready, with one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (expected_q.size() == 0) begin
               flag_error("result transfer with no request outstanding");
            end else begin
               want = expected_q.pop_front();
               if (rsp_pre_divider !== want.pre)
                  flag_error($sformatf("pre_divider got %0d want %0d",
                                       rsp_pre_divider, want.pre));
               if (rsp_post_divider !== want.post)
                  flag_error($sformatf("post_divider got %0d want %0d",
                                       rsp_post_divider, want.post));
               if (rsp_best_error !== want.err)
                  flag_error($sformatf("best_error got %0h want %0h",
                                       rsp_best_error, want.err));
               if (rsp_found !== want.found)
                  flag_error($sformatf("found got %0b want %0b", rsp_found, want.found));
            end
         end
         if (!hold_started && rsp_seen == 10) begin
            hold_started = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (rsp_seen >= 40 && rsp_seen < 70) || $urandom_range(99) >= 7;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("clock_divider_pair_search: mismatch");
            $finish;
         end
      end
   end

   initial begin
      logic [RATE_W-1:0] src;
      logic [RATE_W-1:0] tgt;
      int unsigned div;
      int unsigned kind;

      add_request(32'd0, 32'd0);
      // With a zero source and an all-ones target every error is all ones: no pair found.
      add_request(32'hFFFF_FFFF, 32'd0);
      add_request(32'd0, 32'hFFFF_FFFF);
      add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_request(32'hFFFF_FFFF, 32'd1);
      add_request(32'd1, 32'hFFFF_FFFF);
      add_request(32'd1, 32'd1);
      add_request(32'd5000, 32'd1000);
      add_request(32'd4, 32'd10);
      add_request(32'd0, 32'd100);
      add_request(32'd46875, 32'd24_000_000);
      add_request(32'd1_000_000, 32'd48_000_000);
      add_request(32'h7FFF_FFFF, 32'h8000_0000);
      add_request(32'h8000_0000, 32'h7FFF_FFFF);
      add_request(32'hAAAA_AAAA, 32'h5555_5555);
      add_request(32'h5555_5555, 32'hAAAA_AAAA);
      add_request(32'd25_000_000, 32'd800_000_000);
      add_request(32'd3, 32'd7);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         kind = $urandom_range(99);
         src = $urandom();
         if (kind < 45) begin
            if ($urandom_range(3) == 0) src = src >> $urandom_range(31);
            div = $urandom_range(1, PREDIV_MAX_DEF) * $urandom_range(1, POSTDIV_MAX_DEF);
            tgt = src / RATE_W'(div) + RATE_W'($urandom_range(6)) - RATE_W'(3);
         end else if (kind < 85) begin
            tgt = $urandom();
         end else begin
            src = src >> $urandom_range(31);
            tgt = $urandom() >> $urandom_range(31);
         end
         add_request(tgt, src);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count != total_items || expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_q.size() != 0) flag_error("results still outstanding at the end");
      if (error_count == 0) begin
         $display("clock_divider_pair_search: match");
      end else begin
         $display("clock_divider_pair_search: mismatch");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> clock_divider_pair_search.f
rtl/cdps_pkg.sv
rtl/cdps_div_serial.sv
rtl/clock_divider_pair_search.sv
sim/tb_top.sv
